// ===== sv/mep_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_pkg
// Shared types, constants and the color palette of the Mandelbrot pixel engine.
// ----------------------------------------------------------------------------
package mep_pkg;

	localparam int WIDTH  = 1024;
	localparam int HEIGHT = 768;

	localparam int PIX_W   = 10;
	localparam int CNT_W   = 8;
	localparam int LIM_W   = 16;
	localparam int COLOR_W = 24;
	localparam int ZW      = 14;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ESC_LIMIT = 1'd1;

	localparam logic [CNT_W-1:0] MAX_ITER_RST  = 8'd64;
	localparam logic [LIM_W-1:0] ESC_LIMIT_RST = 16'd40000;

	// Reciprocals for truncating division by 10 and by 100.
	localparam int RECIP10     = 52429;
	localparam int RECIP10_SH  = 19;
	localparam int RECIP100    = 167773;
	localparam int RECIP100_SH = 24;

	typedef logic signed [ZW-1:0] coord_t;

	typedef struct packed {
		coord_t cx;
		coord_t cy;
	} point_t;

	typedef struct packed {
		logic [CNT_W-1:0] max_iterations;
		logic [LIM_W-1:0] escape_limit;
	} cfg_t;

	localparam logic [COLOR_W-1:0] PALETTE [16] = '{
		24'h000000, 24'hAA0000, 24'h00AA00, 24'hAAAA00,
		24'h0000AA, 24'hAA00AA, 24'h00AAAA, 24'hAAAAAA,
		24'h555555, 24'hFF5555, 24'h55FF55, 24'hFFFF55,
		24'h5555FF, 24'hFF55FF, 24'h55FFFF, 24'hFFFFFF
	};

endpackage

// ===== sv/mep_pixel_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_pixel_if
// Request channel carrying one pixel coordinate.
// ----------------------------------------------------------------------------
interface mep_pixel_if;
	logic                     valid;
	logic                     ready;
	logic [mep_pkg::PIX_W-1:0] pixel_x;
	logic [mep_pkg::PIX_W-1:0] pixel_y;

	modport source(output valid, output pixel_x, output pixel_y, input ready);
	modport sink(input valid, input pixel_x, input pixel_y, output ready);
endinterface

// ===== sv/mep_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_result_if
// Result channel carrying the iteration count and palette color of a pixel.
// ----------------------------------------------------------------------------
interface mep_result_if;
	logic                       valid;
	logic                       ready;
	logic [mep_pkg::CNT_W-1:0]   iteration_count;
	logic [mep_pkg::COLOR_W-1:0] pixel_color;

	modport source(output valid, output iteration_count, output pixel_color, input ready);
	modport sink(input valid, input iteration_count, input pixel_color, output ready);
endinterface

// ===== sv/mep_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_front
// Two-stage mapping pipeline from pixel coordinate to the point c at scale 100.
// ----------------------------------------------------------------------------
module mep_front (
	input  logic             clk,
	input  logic             arst_n,
	mep_pixel_if.sink        pixel,
	output logic             out_valid,
	input  logic             out_ready,
	output mep_pkg::point_t  out_point
);
	import mep_pkg::*;

	localparam logic signed [16:0] X_OFS  = 17'(25 * WIDTH);
	localparam coord_t             CY_OFS = coord_t'(HEIGHT);

	logic              vld_s1;
	logic signed [16:0] vx_s1;
	coord_t            cy_s1;
	logic              vld_s2;
	coord_t            cx_s2;
	coord_t            cy_s2;

	logic        s1_go;
	logic        s1_take;
	logic [15:0] px35;
	logic [15:0] vx_mag;
	logic [31:0] vx_prod;
	logic [12:0] vx_quot;
	coord_t      cx_abs;

	assign s1_go   = vld_s1 && (!vld_s2 || out_ready);
	assign s1_take = pixel.valid && pixel.ready;
	assign pixel.ready = !vld_s1 || !vld_s2 || out_ready;

	assign px35 = 16'(pixel.pixel_x) * 16'(35);

	// Truncating division by 10 on sign and magnitude.
	assign vx_mag  = vx_s1[16] ? 16'(-vx_s1) : 16'(vx_s1);
	assign vx_prod = {16'b0, vx_mag} * 32'(RECIP10);
	assign vx_quot = vx_prod[RECIP10_SH +: 13];
	assign cx_abs  = coord_t'({1'b0, vx_quot});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vx_s1  <= '0;
			cy_s1  <= '0;
			cx_s2  <= '0;
			cy_s2  <= '0;
		end else begin
			if (pixel.ready) begin
				vld_s1 <= s1_take;
			end
			if (s1_take) begin
				vx_s1 <= $signed({1'b0, px35}) - X_OFS;
				// Both terms of the row mapping are multiples of 10, so it divides exactly.
				cy_s1 <= $signed({3'b000, pixel.pixel_y, 1'b0}) - CY_OFS;
			end
			if (!vld_s2 || out_ready) begin
				vld_s2 <= vld_s1;
			end
			if (s1_go) begin
				cx_s2 <= vx_s1[16] ? -cx_abs : cx_abs;
				cy_s2 <= cy_s1;
			end
		end
	end

	assign out_valid    = vld_s2;
	assign out_point.cx = cx_s2;
	assign out_point.cy = cy_s2;

endmodule

// ===== sv/mep_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_queue
// Two-entry queue of mapped points between the front end and the iteration core.
// ----------------------------------------------------------------------------
module mep_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  mep_pkg::point_t  in_point,
	output logic             out_valid,
	input  logic             out_ready,
	output mep_pkg::point_t  out_point
);
	import mep_pkg::*;

	point_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	logic push;
	logic pop;

	assign in_ready  = (fill_q != 2'd2);
	assign out_valid = (fill_q != 2'd0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_point = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_point;
		end
	end

endmodule

// ===== sv/mep_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_core
// Escape-time iteration engine with a registered result stage and palette lookup.
// ----------------------------------------------------------------------------
module mep_core (
	input  logic             clk,
	input  logic             arst_n,
	input  mep_pkg::cfg_t    cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  mep_pkg::point_t  in_point,
	mep_result_if.source     result
);
	import mep_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_UPD, ST_FIN} state_t;

	state_t              state_q;
	coord_t              cx_q;
	coord_t              cy_q;
	coord_t              zx_q;
	coord_t              zy_q;
	logic [26:0]         xx_q;
	logic [26:0]         yy_q;
	logic signed [27:0]  xy_q;
	logic [CNT_W-1:0]    count_q;
	logic                res_valid_q;
	logic [CNT_W-1:0]    res_count_q;
	logic [COLOR_W-1:0]  res_color_q;

	logic signed [27:0] zx_w;
	logic signed [27:0] zy_w;
	logic signed [27:0] sq_x;
	logic signed [27:0] sq_y;
	logic [27:0]        mag_sum;
	logic               stop;
	logic               out_free;
	logic               res_load;
	logic signed [27:0] dxx;
	logic [15:0]        dx_mag;
	logic [27:0]        xy_abs;
	logic [15:0]        dy_mag;
	logic [33:0]        qx_prod;
	logic [33:0]        qy_prod;
	coord_t             qx;
	coord_t             qy;
	coord_t             nx;
	coord_t             ny;

	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !res_valid_q || result.ready;
	assign res_load = out_free && ((state_q == ST_FIN) || (state_q == ST_UPD && stop));

	assign zx_w = 28'(zx_q);
	assign zy_w = 28'(zy_q);
	assign sq_x = zx_w * zx_w;
	assign sq_y = zy_w * zy_w;

	assign mag_sum = {1'b0, xx_q} + {1'b0, yy_q};
	assign stop    = (mag_sum > 28'(cfg.escape_limit)) || (count_q >= cfg.max_iterations);

	// While the bound holds, both numerators stay within 16 bits of magnitude.
	assign dxx     = $signed({1'b0, xx_q}) - $signed({1'b0, yy_q});
	assign dx_mag  = dxx[27] ? 16'(-dxx) : 16'(dxx);
	assign xy_abs  = xy_q[27] ? 28'(-xy_q) : 28'(xy_q);
	assign dy_mag  = {xy_abs[14:0], 1'b0};
	assign qx_prod = 34'(dx_mag) * 34'(RECIP100);
	assign qy_prod = 34'(dy_mag) * 34'(RECIP100);
	assign qx      = coord_t'({4'b0000, qx_prod[RECIP100_SH +: 10]});
	assign qy      = coord_t'({4'b0000, qy_prod[RECIP100_SH +: 10]});
	assign nx      = (dxx[27] ? -qx : qx) + cx_q;
	assign ny      = (xy_q[27] ? -qy : qy) + cy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cx_q        <= '0;
			cy_q        <= '0;
			zx_q        <= '0;
			zy_q        <= '0;
			xx_q        <= '0;
			yy_q        <= '0;
			xy_q        <= '0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
			res_count_q <= '0;
			res_color_q <= '0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cx_q    <= in_point.cx;
						cy_q    <= in_point.cy;
						zx_q    <= '0;
						zy_q    <= '0;
						count_q <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					xx_q    <= 27'(sq_x);
					yy_q    <= 27'(sq_y);
					xy_q    <= zx_w * zy_w;
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (stop) begin
						if (out_free) begin
							res_count_q <= count_q;
							res_color_q <= PALETTE[count_q[3:0]];
							state_q     <= ST_IDLE;
						end else begin
							state_q <= ST_FIN;
						end
					end else begin
						zx_q    <= nx;
						zy_q    <= ny;
						count_q <= count_q + 8'd1;
						state_q <= ST_MUL;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						res_count_q <= count_q;
						res_color_q <= PALETTE[count_q[3:0]];
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result.valid           = res_valid_q;
	assign result.iteration_count = res_count_q;
	assign result.pixel_color     = res_color_q;

	a_mul_then_upd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |=> (state_q == ST_UPD))
		else $error("multiply cycle not followed by update");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (count_q <= cfg.max_iterations))
		else $error("iteration count beyond maximum");

	a_fin_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free) |=> (res_valid_q && state_q == ST_IDLE))
		else $error("finished pixel not loaded into result stage");

endmodule

// ===== sv/mandelbrot_escape_pixel_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_top
// Mandelbrot escape-time engine: pixel coordinate in, iteration count and color out.
// ----------------------------------------------------------------------------
// A pixel request on the pixel channel carries a column and a row. The front
// end maps it to a point c at scale 100 in two pipeline stages and places it
// in a two-entry queue. The core pops one point at a time and runs each step
// of the recurrence in state ST_MUL, for the three squaring multipliers, and
// then in ST_UPD, for the escape test, the reciprocal divisions by 100 and
// the update of z. The core takes no new point until it is back in ST_IDLE,
// which sets the throughput; the front end overlaps with it. Results leave
// through a register on the result channel in request order. If the
// receiver stalls, the core holds a finished pixel until the result
// register frees up, while the front end and queue keep taking up to four
// further requests. Reset empties all stages and sets max_iterations to 64
// and escape_limit to 40000; writes to them belong only where no request is
// in flight.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mep_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mep_pkg::CFG_DATA_W-1:0] cfg_wdata,
	mep_pixel_if.sink                      pixel,
	mep_result_if.source                   result
);
	import mep_pkg::*;

	cfg_t   cfg_q;
	logic   fr_valid;
	logic   fr_ready;
	point_t fr_point;
	logic   qu_valid;
	logic   qu_ready;
	point_t qu_point;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_iterations <= MAX_ITER_RST;
			cfg_q.escape_limit   <= ESC_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_ITER:  cfg_q.max_iterations <= cfg_wdata[CNT_W-1:0];
				REG_ESC_LIMIT: cfg_q.escape_limit   <= cfg_wdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	mep_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pixel),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_point (fr_point)
	);

	mep_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_point  (fr_point),
		.out_valid (qu_valid),
		.out_ready (qu_ready),
		.out_point (qu_point)
	);

	mep_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (qu_valid),
		.in_ready (qu_ready),
		.in_point (qu_point),
		.result   (result)
	);

endmodule

// ===== sim/mandelbrot_escape_pixel_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_top_tb
// Self-checking bench for the Mandelbrot escape-time pixel engine.
// ----------------------------------------------------------------------------
// Pixel requests go in through the pixel channel. For each one without a typed
// table result, an escape-time calculation in 64-bit arithmetic works out the
// iteration count and color under the current register values. Every result
// on the result channel is compared with the oldest open expectation. A short
// table covers corners, screen edges, zero maximum, zero escape limit and the
// largest settings, then random phases under several register settings. Both
// channels stall in random bursts in the table and in random phases but the last.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_top_tb;
	import mep_pkg::*;

	localparam int CYCLE_LIMIT   = 3000000;
	localparam int TAIL_CYCLES   = 520;
	localparam int PHASE_COUNT   = 10;
	localparam int PHASE_PIXELS  = 85;
	localparam int TABLE_ROWS    = 24;

	typedef struct packed {
		logic [CNT_W-1:0]   count;
		logic [COLOR_W-1:0] color;
	} escape_result_t;

	typedef struct packed {
		logic [PIX_W-1:0]   col;
		logic [PIX_W-1:0]   row;
		logic [CNT_W-1:0]   iters;
		logic [LIM_W-1:0]   limit;
		logic               typed;
		logic [CNT_W-1:0]   count;
		logic [COLOR_W-1:0] color;
	} table_row_t;

	// Color for each value of the count mod 16.
	localparam logic [COLOR_W-1:0] HUES [16] = '{
		24'h000000, 24'hAA0000, 24'h00AA00, 24'hAAAA00,
		24'h0000AA, 24'hAA00AA, 24'h00AAAA, 24'hAAAAAA,
		24'h555555, 24'hFF5555, 24'h55FF55, 24'hFFFF55,
		24'h5555FF, 24'hFF55FF, 24'h55FFFF, 24'hFFFFFF
	};

	// Pixel 731/384 maps to c = (-1, 0): z sits at (-1, 0), so the maximum is reached.
	localparam table_row_t STIM_TABLE [TABLE_ROWS] = '{
		'{10'd0,    10'd0,    8'd64,  16'd40000, 1'b1, 8'd1,   24'hAA0000},
		'{10'd1023, 10'd1023, 8'd64,  16'd40000, 1'b1, 8'd1,   24'hAA0000},
		'{10'd1023, 10'd0,    8'd64,  16'd40000, 1'b1, 8'd1,   24'hAA0000},
		'{10'd0,    10'd1023, 8'd64,  16'd40000, 1'b1, 8'd1,   24'hAA0000},
		'{10'd731,  10'd384,  8'd64,  16'd40000, 1'b1, 8'd64,  24'h000000},
		'{10'd700,  10'd384,  8'd64,  16'd40000, 1'b0, 8'd0,   24'h000000},
		'{10'd720,  10'd300,  8'd64,  16'd40000, 1'b0, 8'd0,   24'h000000},
		'{10'd740,  10'd400,  8'd64,  16'd40000, 1'b0, 8'd0,   24'h000000},
		'{10'd730,  10'd385,  8'd64,  16'd40000, 1'b0, 8'd0,   24'h000000},
		'{10'd731,  10'd768,  8'd64,  16'd40000, 1'b0, 8'd0,   24'h000000},
		'{10'd682,  10'd341,  8'd64,  16'd40000, 1'b0, 8'd0,   24'h000000},
		'{10'd341,  10'd682,  8'd64,  16'd40000, 1'b0, 8'd0,   24'h000000},
		'{10'd682,  10'd1000, 8'd64,  16'd40000, 1'b0, 8'd0,   24'h000000},
		'{10'd731,  10'd384,  8'd0,   16'd40000, 1'b1, 8'd0,   24'h000000},
		'{10'd0,    10'd0,    8'd0,   16'd40000, 1'b1, 8'd0,   24'h000000},
		'{10'd731,  10'd384,  8'd255, 16'd0,     1'b1, 8'd1,   24'hAA0000},
		'{10'd700,  10'd384,  8'd255, 16'd0,     1'b0, 8'd0,   24'h000000},
		'{10'd731,  10'd384,  8'd255, 16'd65535, 1'b1, 8'd255, 24'hFFFFFF},
		'{10'd700,  10'd384,  8'd255, 16'd65535, 1'b0, 8'd0,   24'h000000},
		'{10'd1023, 10'd1023, 8'd255, 16'd65535, 1'b1, 8'd1,   24'hAA0000},
		'{10'd720,  10'd350,  8'd1,   16'd65535, 1'b1, 8'd1,   24'hAA0000},
		'{10'd731,  10'd384,  8'd15,  16'd40000, 1'b1, 8'd15,  24'hFFFFFF},
		'{10'd731,  10'd384,  8'd16,  16'd40000, 1'b1, 8'd16,  24'h000000},
		'{10'd710,  10'd390,  8'd16,  16'd40000, 1'b0, 8'd0,   24'h000000}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	mep_pixel_if  pixel_ch();
	mep_result_if result_ch();

	mandelbrot_escape_pixel_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pixel     (pixel_ch),
		.result    (result_ch)
	);

	logic [CNT_W-1:0] cur_iters = MAX_ITER_RST;
	logic [LIM_W-1:0] cur_limit = ESC_LIMIT_RST;
	escape_result_t   open_results [$];
	bit               idle_on;
	int               error_count;
	int               checked_count;
	int               table_sent;
	int               random_sent;
	int               setting_count;
	int               cycle_count;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout with %0d results outstanding", $time, open_results.size());
		$display("** mandelbrot_escape_pixel_top: FAILED **");
		$finish;
	end

	function automatic escape_result_t predict_escape(input logic [PIX_W-1:0] col,
			input logic [PIX_W-1:0] row);
		longint cx;
		longint cy;
		longint zx;
		longint zy;
		longint nx;
		int steps;
		escape_result_t res;
		cx = (longint'(col) * 35 - 25 * WIDTH) / 10;
		cy = (longint'(row) * 20 - 10 * HEIGHT) / 10;
		zx = 0;
		zy = 0;
		steps = 0;
		while (zx * zx + zy * zy <= longint'(cur_limit) && steps < int'(cur_iters)) begin
			nx = (zx * zx - zy * zy) / 100 + cx;
			zy = (2 * zx * zy) / 100 + cy;
			zx = nx;
			steps++;
		end
		res.count = steps[CNT_W-1:0];
		res.color = HUES[steps[3:0]];
		return res;
	endfunction

	// Most random pixels land around the set, where the iteration runs long.
	task automatic pick_pixel(output logic [PIX_W-1:0] col, output logic [PIX_W-1:0] row);
		if ($urandom_range(0, 9) < 6) begin
			col = $urandom_range(674, 746);
			row = $urandom_range(324, 444);
		end else begin
			col = $urandom_range(0, 1023);
			row = $urandom_range(0, 1023);
		end
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row,
			input logic use_typed, input escape_result_t typed_res);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			pixel_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		pixel_ch.valid   <= 1'b1;
		pixel_ch.pixel_x <= col;
		pixel_ch.pixel_y <= row;
		do @(posedge clk); while (!pixel_ch.ready);
		open_results.push_back(use_typed ? typed_res : predict_escape(col, row));
	endtask

	task automatic wait_for_results();
		pixel_ch.valid <= 1'b0;
		while (open_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// The upper data bits on the iteration register write are random and must be ignored.
	task automatic write_config(input logic [CNT_W-1:0] iters, input logic [LIM_W-1:0] limit);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MAX_ITER;
		cfg_wdata <= {8'($urandom), iters};
		@(posedge clk);
		cur_iters = iters;
		cfg_index <= REG_ESC_LIMIT;
		cfg_wdata <= limit;
		@(posedge clk);
		cur_limit = limit;
		cfg_we <= 1'b0;
		setting_count++;
	endtask

	initial begin : result_side
		int stall_left;
		escape_result_t want;
		stall_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				if (open_results.size() == 0) begin
					$display("%0t: result with none expected: count %0d, color %06h",
						$time, result_ch.iteration_count, result_ch.pixel_color);
					error_count++;
				end else begin
					want = open_results.pop_front();
					checked_count++;
					if (result_ch.iteration_count !== want.count) begin
						$display("%0t: iteration_count expected %0d, got %0d",
							$time, want.count, result_ch.iteration_count);
						error_count++;
					end
					if (result_ch.pixel_color !== want.color) begin
						$display("%0t: pixel_color expected %06h, got %06h",
							$time, want.color, result_ch.pixel_color);
						error_count++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 5) - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		logic [PIX_W-1:0] col;
		logic [PIX_W-1:0] row;
		logic [CNT_W-1:0] iters;
		logic [LIM_W-1:0] limit;
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= REG_MAX_ITER;
		cfg_wdata        <= '0;
		pixel_ch.valid   <= 1'b0;
		pixel_ch.pixel_x <= '0;
		pixel_ch.pixel_y <= '0;
		idle_on = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (STIM_TABLE[i]) begin
			if (STIM_TABLE[i].iters != cur_iters || STIM_TABLE[i].limit != cur_limit) begin
				wait_for_results();
				write_config(STIM_TABLE[i].iters, STIM_TABLE[i].limit);
			end
			send_pixel(STIM_TABLE[i].col, STIM_TABLE[i].row, STIM_TABLE[i].typed,
				'{STIM_TABLE[i].count, STIM_TABLE[i].color});
			table_sent++;
		end

		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph)
				0: begin
					iters = 8'd64;
					limit = 16'd40000;
				end
				1: begin
					iters = 8'd255;
					limit = 16'd65535;
				end
				2: begin
					iters = 8'd0;
					limit = 16'($urandom);
				end
				3: begin
					iters = 8'd1;
					limit = 16'd0;
				end
				4: begin
					iters = 8'd255;
					limit = 16'd0;
				end
				7: begin
					iters = 8'd128;
					limit = 16'd10000;
				end
				8: begin
					iters = 8'd32;
					limit = 16'd65535;
				end
				9: begin
					iters = MAX_ITER_RST;
					limit = ESC_LIMIT_RST;
				end
				default: begin
					iters = $urandom_range(1, 255);
					limit = 16'($urandom);
				end
			endcase
			wait_for_results();
			idle_on = (ph == PHASE_COUNT - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
			write_config(iters, limit);
			repeat (PHASE_PIXELS) begin
				pick_pixel(col, row);
				send_pixel(col, row, 1'b0, '0);
				random_sent++;
			end
		end

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Checked %0d results from %0d table and %0d random pixel requests.",
			checked_count, table_sent, random_sent);
		$display("Register settings applied: %0d, mismatches: %0d.", setting_count, error_count);
		if (error_count == 0) begin
			$display("** mandelbrot_escape_pixel_top: PASSED **");
		end else begin
			$display("** mandelbrot_escape_pixel_top: FAILED **");
		end
		$finish;
	end

endmodule
